// File: rtl/core/cabr_pkg.sv
// cabr_pkg: constants, types and arithmetic helpers for the comb/allpass reverb
// used by comb_allpass_reverb and the test benches; depends on nothing else
package cabr_pkg;

	// delay line lengths, combs a..d then allpasses a..b
	localparam int COMB_LEN_A    = 1214;
	localparam int COMB_LEN_B    = 1293;
	localparam int COMB_LEN_C    = 1389;
	localparam int COMB_LEN_D    = 1475;
	localparam int ALLPASS_LEN_A = 605;
	localparam int ALLPASS_LEN_B = 480;

	localparam int NUM_COMBS  = 4;
	localparam int NUM_LINES  = 6;
	localparam int LINE_IDX_W = $clog2(NUM_LINES);
	localparam int COMB_IDX_W = $clog2(NUM_COMBS);

	localparam int unsigned LINE_LEN [NUM_LINES] = '{
		COMB_LEN_A, COMB_LEN_B, COMB_LEN_C, COMB_LEN_D, ALLPASS_LEN_A, ALLPASS_LEN_B
	};

	// all six lines share one memory, laid out back to back
	localparam int MEM_DEPTH = COMB_LEN_A + COMB_LEN_B + COMB_LEN_C + COMB_LEN_D
		+ ALLPASS_LEN_A + ALLPASS_LEN_B;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int POS_W     = 11;
	localparam int LEN_W     = POS_W + 1;

	// number formats
	localparam int SAMPLE_W = 24;
	localparam int DATA_W   = 32;
	localparam int COEF_W   = 16;
	localparam int MUL_B_W  = COEF_W + 1;
	localparam int PROD_W   = DATA_W + MUL_B_W + 1;
	localparam int ACC_W    = PROD_W + 2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ROOM_FEEDBACK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WET_MIX       = 2'd2;

	localparam logic [COEF_W-1:0] ROOM_FEEDBACK_RST = 16'd19661;
	localparam logic [COEF_W-1:0] DAMPING_RST       = 16'd36045;
	localparam logic [COEF_W-1:0] WET_MIX_RST       = 16'd7864;

	// input gain of about 0.015 and the Q0.16 one
	localparam logic [MUL_B_W-1:0] IN_GAIN = 17'd983;
	localparam logic [MUL_B_W-1:0] UNITY   = 17'd65536;

	localparam logic [LINE_IDX_W-1:0] LAST_COMB = LINE_IDX_W'(NUM_COMBS - 1);
	localparam logic [LINE_IDX_W-1:0] LAST_LINE = LINE_IDX_W'(NUM_LINES - 1);

	localparam logic signed [ACC_W-1:0] DATA_MAX_A =
		{{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] DATA_MIN_A =
		{{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] SAMPLE_MAX_A =
		{{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAMPLE_MIN_A =
		{{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] ROUND_HALF =
		{{(ACC_W-COEF_W){1'b0}}, 1'b1, {(COEF_W-1){1'b0}}};
	localparam logic signed [DATA_W:0] ONE_WIDE = {{DATA_W{1'b0}}, 1'b1};

	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XMUL,
		ST_XRND,
		ST_CRD,
		ST_CM1,
		ST_CM2,
		ST_CM3,
		ST_CM4,
		ST_CM5,
		ST_ARD,
		ST_AP1,
		ST_AP2,
		ST_WMUL,
		ST_OUT
	} state_t;

	function automatic logic signed [ACC_W-1:0] sext_acc(input data_t a);
		return {{(ACC_W-DATA_W){a[DATA_W-1]}}, a};
	endfunction

	function automatic logic signed [ACC_W-1:0] sext_prod(input logic signed [PROD_W-1:0] p);
		return {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
	endfunction

	// clamp to the signed 32-bit range
	function automatic data_t sat32(input logic signed [ACC_W-1:0] v);
		data_t r;
		if (v > DATA_MAX_A) begin
			r = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (v < DATA_MIN_A) begin
			r = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	// drop the 16 coefficient fraction bits, round half up, saturate
	function automatic data_t rnd_q16(input logic signed [ACC_W-1:0] p);
		logic signed [ACC_W-1:0] r;
		r = (p + ROUND_HALF) >>> COEF_W;
		return sat32(r);
	endfunction

	// halve with round half up
	function automatic data_t half_rnd(input data_t a);
		logic signed [DATA_W:0] t;
		t = {a[DATA_W-1], a} + ONE_WIDE;
		return t[DATA_W:1];
	endfunction

	function automatic data_t add_sat(input data_t a, input data_t b);
		return sat32(sext_acc(a) + sext_acc(b));
	endfunction

	function automatic data_t sub_sat(input data_t a, input data_t b);
		return sat32(sext_acc(a) - sext_acc(b));
	endfunction

	// first memory address of a line
	function automatic logic [ADDR_W-1:0] line_base(input logic [LINE_IDX_W-1:0] idx);
		logic [ADDR_W-1:0] b;
		b = '0;
		for (int i = 0; i < NUM_LINES; i++) begin
			if (LINE_IDX_W'(i) < idx) begin
				b = b + ADDR_W'(LINE_LEN[i]);
			end
		end
		return b;
	endfunction

	// clamp to the Q1.23 sample range
	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > SAMPLE_MAX_A) begin
			r = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else if (v < SAMPLE_MIN_A) begin
			r = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/cabr_ram.sv
// cabr_ram: generic simple dual-port RAM, one write and one registered read port
// depends on nothing else
module cabr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/comb_allpass_reverb.sv
// comb_allpass_reverb: four damped combs and two allpasses, dry plus wet mix
// depends on cabr_pkg and cabr_ram
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+---------------------------------
//  in      | sink      | in_valid / in_stall  | sample_in, last_of_period
//  out     | source    | out_valid / out_stall| sample_out, period_end
//  cfg     | sink      | cfg_we               | cfg_index, cfg_data
//
// An item is accepted only in ST_IDLE, so a new one waits for the current one:
// one shared 32x17 multiplier and six read-modify-write passes over the single
// delay-line RAM, states CRD and CM1..CM5 per comb and ARD, AP1, AP2 per allpass.
// Reset needs no clearing pass: a per-line wrap flag makes entries that were
// never written read as zero. A stalled result waits in the output register
// while the next input beat is taken and worked on.
module comb_allpass_reverb (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [cabr_pkg::SAMPLE_W-1:0]     sample_in,
	input  logic                                     last_of_period,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [cabr_pkg::SAMPLE_W-1:0]     sample_out,
	output logic                                     period_end,
	input  logic                                     cfg_we,
	input  logic [cabr_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [cabr_pkg::COEF_W-1:0]              cfg_data
);

	import cabr_pkg::*;

	state_t state_q, state_nxt;

	logic [COEF_W-1:0] room_feedback_q, damping_q, wet_mix_q;

	logic [LINE_IDX_W-1:0] idx_q;
	logic [POS_W-1:0]      pos_q [NUM_LINES];
	logic [NUM_LINES-1:0]  full_q;
	data_t                 lp_q [NUM_COMBS];

	logic signed [SAMPLE_W-1:0] dry_q;
	logic                       flag_q;
	data_t                      x_q, sum_q, y_q, v_q, last_q;
	logic signed [PROD_W-1:0]   prod_q, acc_q;

	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;
	logic                       period_end_q;

	data_t              mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic               ram_re, ram_we, advance;
	data_t              ram_wdata, ram_rdata, y_rd, v_new, last_new;
	logic [ADDR_W-1:0]  line_addr;
	logic               in_acc, out_free;
	logic [LEN_W-1:0]   pos_inc;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// current entry of the active line, zero until the line has wrapped once
	assign line_addr = line_base(idx_q) + ADDR_W'(pos_q[idx_q]);
	assign y_rd      = full_q[idx_q] ? ram_rdata : '0;
	assign last_new  = rnd_q16(sext_prod(acc_q) + sext_prod(prod_q));
	assign v_new     = add_sat(sum_q, half_rnd(y_rd));
	assign pos_inc   = {1'b0, pos_q[idx_q]} + LEN_W'(1);

	cabr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MEM_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (line_addr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (line_addr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_XMUL;
			ST_XMUL: state_nxt = ST_XRND;
			ST_XRND: state_nxt = ST_CRD;
			ST_CRD:  state_nxt = ST_CM1;
			ST_CM1:  state_nxt = ST_CM2;
			ST_CM2:  state_nxt = ST_CM3;
			ST_CM3:  state_nxt = ST_CM4;
			ST_CM4:  state_nxt = ST_CM5;
			ST_CM5:  state_nxt = (idx_q == LAST_COMB) ? ST_ARD : ST_CRD;
			ST_ARD:  state_nxt = ST_AP1;
			ST_AP1:  state_nxt = ST_AP2;
			ST_AP2:  state_nxt = (idx_q == LAST_LINE) ? ST_WMUL : ST_ARD;
			ST_WMUL: state_nxt = ST_OUT;
			ST_OUT:  if (out_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands and memory strobes
	always_comb begin
		in_stall  = 1'b1;
		mul_a     = '0;
		mul_b     = '0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = '0;
		advance   = 1'b0;
		unique case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_XMUL: begin
				mul_a = {{(DATA_W-SAMPLE_W){dry_q[SAMPLE_W-1]}}, dry_q};
				mul_b = IN_GAIN;
			end
			ST_CRD:  ram_re = 1'b1;
			ST_CM1: begin
				mul_a = y_rd;
				mul_b = UNITY - {1'b0, damping_q};
			end
			ST_CM2: begin
				mul_a = lp_q[idx_q[COMB_IDX_W-1:0]];
				mul_b = {1'b0, damping_q};
			end
			ST_CM4: begin
				mul_a = last_q;
				mul_b = {1'b0, room_feedback_q};
			end
			ST_CM5: begin
				ram_we    = 1'b1;
				ram_wdata = add_sat(x_q, rnd_q16(sext_prod(prod_q)));
				advance   = 1'b1;
			end
			ST_ARD:  ram_re = 1'b1;
			ST_AP1: begin
				ram_we    = 1'b1;
				ram_wdata = v_new;
				advance   = 1'b1;
			end
			// wet product is held while the result waits for the output register
			ST_WMUL, ST_OUT: begin
				mul_a = sum_q;
				mul_b = {1'b0, wet_mix_q};
			end
			ST_XRND, ST_CM3, ST_AP2: ;
			default: ;
		endcase
	end

	// control state, line positions, lowpass memory and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			idx_q           <= '0;
			full_q          <= '0;
			room_feedback_q <= ROOM_FEEDBACK_RST;
			damping_q       <= DAMPING_RST;
			wet_mix_q       <= WET_MIX_RST;
			for (int i = 0; i < NUM_LINES; i++) begin
				pos_q[i] <= '0;
			end
			for (int i = 0; i < NUM_COMBS; i++) begin
				lp_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				case (cfg_index)
					REG_ROOM_FEEDBACK: room_feedback_q <= cfg_data;
					REG_DAMPING:       damping_q       <= cfg_data;
					REG_WET_MIX:       wet_mix_q       <= cfg_data;
					default: ;
				endcase
			end
			if (in_acc) begin
				idx_q <= '0;
			end else if (state_q == ST_CM5 || state_q == ST_AP2) begin
				idx_q <= idx_q + LINE_IDX_W'(1);
			end
			if (state_q == ST_CM3) begin
				lp_q[idx_q[COMB_IDX_W-1:0]] <= last_new;
			end
			// position wraps at the line length, marking the line as filled
			if (advance) begin
				if (pos_inc >= LEN_W'(LINE_LEN[idx_q])) begin
					pos_q[idx_q]  <= '0;
					full_q[idx_q] <= 1'b1;
				end else begin
					pos_q[idx_q] <= pos_inc[POS_W-1:0];
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * $signed({1'b0, mul_b});
		if (in_acc) begin
			dry_q  <= sample_in;
			flag_q <= last_of_period;
			sum_q  <= '0;
		end
		case (state_q)
			ST_XRND: x_q <= rnd_q16(sext_prod(prod_q));
			ST_CM1:  y_q <= y_rd;
			ST_CM2:  acc_q <= prod_q;
			ST_CM3: begin
				last_q <= last_new;
				sum_q  <= add_sat(sum_q, y_q);
			end
			ST_AP1: begin
				y_q <= y_rd;
				v_q <= v_new;
			end
			ST_AP2:  sum_q <= sub_sat(y_q, half_rnd(v_q));
			default: ;
		endcase
		if (state_q == ST_OUT && out_free) begin
			sample_out_q <= sat_sample(
				{{(ACC_W-SAMPLE_W){dry_q[SAMPLE_W-1]}}, dry_q}
				+ sext_acc(rnd_q16(sext_prod(prod_q))));
			period_end_q <= flag_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign period_end = period_end_q;

endmodule

// File: test/reverb_checker.sv
// reverb_checker: watches the sample channels and register writes of comb_allpass_reverb,
// predicts every output beat and compares it field by field; depends on cabr_pkg
`timescale 1ns / 1ps

module reverb_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [cabr_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                 last_of_period,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [cabr_pkg::SAMPLE_W-1:0] sample_out,
	input  logic                                 period_end,
	input  logic                                 cfg_we,
	input  logic [cabr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cabr_pkg::COEF_W-1:0]          cfg_data,
	output int                                   fail_count,
	output int                                   outstanding
);

	import cabr_pkg::*;

	localparam longint WORD_MAX   = 64'sd2147483647;
	localparam longint WORD_MIN   = -64'sd2147483648;
	localparam longint SAMPLE_TOP = 64'sd8388607;
	localparam longint SAMPLE_BOT = -64'sd8388608;
	localparam int     SLOT_DEPTH = 2048;

	typedef struct {
		logic signed [SAMPLE_W-1:0] mixed;
		logic                       flag;
	} out_beat_t;

	// predictor state: delay lines, lowpass memories, positions, coefficients
	data_t            line_mem [NUM_LINES][SLOT_DEPTH];
	data_t            lowpass_mem [NUM_COMBS];
	logic [POS_W-1:0] line_pos [NUM_LINES];
	logic [COEF_W-1:0] room_coef;
	logic [COEF_W-1:0] damp_coef;
	logic [COEF_W-1:0] wet_coef;

	out_beat_t expected_out [$];
	out_beat_t head;
	out_beat_t fresh;
	int        fails;

	assign fail_count = fails;

	function automatic data_t clamp_word(input longint v);
		if (v > WORD_MAX) return data_t'(WORD_MAX);
		if (v < WORD_MIN) return data_t'(WORD_MIN);
		return data_t'(v);
	endfunction

	// Q9.23 times unsigned Q1.16, round half up
	function automatic data_t coef_mul(input data_t a, input logic [COEF_W:0] c);
		longint p;
		p = longint'(a) * longint'(c);
		return clamp_word((p + 64'sd32768) >>> 16);
	endfunction

	function automatic data_t halve_up(input data_t a);
		longint t;
		t = (longint'(a) + 64'sd1) >>> 1;
		return data_t'(t);
	endfunction

	// read position of a line, then step it with wrap
	function automatic int take_pos(input int k);
		int p;
		p = int'(line_pos[k]);
		line_pos[k] = (p + 1 >= int'(LINE_LEN[k])) ? '0 : POS_W'(p + 1);
		return p;
	endfunction

	// damped feedback comb
	function automatic data_t comb_pass(input int k, input data_t x);
		int     p;
		data_t  y;
		data_t  lp;
		longint acc;
		p = take_pos(k);
		y = line_mem[k][p];
		acc = longint'(y) * (64'sd65536 - longint'(damp_coef))
			+ longint'(lowpass_mem[k]) * longint'(damp_coef);
		lp = clamp_word((acc + 64'sd32768) >>> 16);
		lowpass_mem[k] = lp;
		line_mem[k][p] = clamp_word(longint'(x) + longint'(coef_mul(lp, {1'b0, room_coef})));
		return y;
	endfunction

	// allpass with gain one half
	function automatic data_t allpass_pass(input int k, input data_t x);
		int    p;
		data_t y;
		data_t v;
		p = take_pos(k);
		y = line_mem[k][p];
		v = clamp_word(longint'(x) + longint'(halve_up(y)));
		line_mem[k][p] = v;
		return clamp_word(longint'(y) - longint'(halve_up(v)));
	endfunction

	// one dry sample in, one mixed sample out
	function automatic logic signed [SAMPLE_W-1:0] reverb_sample(
		input logic signed [SAMPLE_W-1:0] dry);
		data_t  x;
		data_t  acc_sum;
		longint o;
		x = coef_mul(data_t'(dry), IN_GAIN);
		acc_sum = '0;
		for (int k = 0; k < NUM_COMBS; k++) begin
			acc_sum = clamp_word(longint'(acc_sum) + longint'(comb_pass(k, x)));
		end
		acc_sum = allpass_pass(NUM_LINES - 2, acc_sum);
		acc_sum = allpass_pass(NUM_LINES - 1, acc_sum);
		o = longint'(dry) + longint'(coef_mul(acc_sum, {1'b0, wet_coef}));
		if (o > SAMPLE_TOP) o = SAMPLE_TOP;
		if (o < SAMPLE_BOT) o = SAMPLE_BOT;
		return o[SAMPLE_W-1:0];
	endfunction

	// track writes, check output beats, predict input beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_LINES; k++) begin
				line_pos[k] = '0;
				for (int i = 0; i < SLOT_DEPTH; i++) begin
					line_mem[k][i] = '0;
				end
			end
			for (int k = 0; k < NUM_COMBS; k++) begin
				lowpass_mem[k] = '0;
			end
			room_coef = ROOM_FEEDBACK_RST;
			damp_coef = DAMPING_RST;
			wet_coef = WET_MIX_RST;
			expected_out.delete();
			fails = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROOM_FEEDBACK: room_coef = cfg_data;
					REG_DAMPING:       damp_coef = cfg_data;
					REG_WET_MIX:       wet_coef = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_out.size() == 0) begin
					$error("sample_out beat with nothing expected: %0d", sample_out);
					fails++;
				end else begin
					head = expected_out.pop_front();
					if (sample_out !== head.mixed) begin
						$error("sample_out expected %0d actual %0d", head.mixed, sample_out);
						fails++;
					end
					if (period_end !== head.flag) begin
						$error("period_end expected %0b actual %0b", head.flag, period_end);
						fails++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				fresh.mixed = reverb_sample(sample_in);
				fresh.flag = last_of_period;
				expected_out.push_back(fresh);
			end
			outstanding <= expected_out.size();
		end
	end

endmodule

// File: test/comb_allpass_reverb_test.sv
// comb_allpass_reverb_test: drives samples and coefficient writes into comb_allpass_reverb
// and gives the verdict; depends on cabr_pkg, comb_allpass_reverb and reverb_checker
`timescale 1ns / 1ps

module comb_allpass_reverb_test;
	import cabr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int NUM_PHASES     = 6;
	localparam int PHASE_ITEMS    = 206;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_AT        = 150;
	localparam int HOLD_CYCLES    = 600;
	localparam int SETTLE_CYCLES  = 40;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic                       last_of_period = 1'b0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       period_end;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [COEF_W-1:0]          cfg_data = '0;

	int fail_count;
	int outstanding;
	int tx_idle_pct = 9;
	int rx_idle_pct = 51;
	int rx_taken = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;

	comb_allpass_reverb dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_in(sample_in), .last_of_period(last_of_period),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample_out(sample_out), .period_end(period_end),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	reverb_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_in(sample_in), .last_of_period(last_of_period),
		.out_valid(out_valid), .out_stall(out_stall),
		.sample_out(sample_out), .period_end(period_end),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// output side: random stalls plus one long hold after HOLD_AT accepted input beats
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			rx_taken++;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (rx_taken == HOLD_AT && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
		end
	end

	// give up when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("comb_allpass_reverb verification failed");
			$finish;
		end
	end

	// offer one sample beat and hold it until taken
	task automatic send_beat(input logic signed [SAMPLE_W-1:0] s, input logic f);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= s;
		last_of_period <= f;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	// stop offering and wait for every output beat
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// write all coefficients back to back, spare index first
	task automatic set_coefs(input logic [COEF_W-1:0] fb, input logic [COEF_W-1:0] dp,
		input logic [COEF_W-1:0] wet);
		cfg_we <= 1'b1;
		cfg_index <= REG_SPARE;
		cfg_data <= COEF_W'($urandom);
		@(posedge clk);
		cfg_index <= REG_ROOM_FEEDBACK;
		cfg_data <= fb;
		@(posedge clk);
		cfg_index <= REG_DAMPING;
		cfg_data <= dp;
		@(posedge clk);
		cfg_index <= REG_WET_MIX;
		cfg_data <= wet;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// mostly full-scale noise, some quiet passages and clipped peaks
	task automatic pick_sample(output logic signed [SAMPLE_W-1:0] s, output logic f);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			s = $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
		end else if (sel < 3) begin
			s = SAMPLE_W'($signed($urandom_range(0, 8192)) - 4096);
		end else begin
			s = SAMPLE_W'($urandom);
		end
		f = ($urandom_range(0, 7) == 0);
	endtask

	initial begin
		logic signed [SAMPLE_W-1:0] s;
		logic f;
		logic signed [SAMPLE_W-1:0] corner [16];

		corner = '{24'sh000000, 24'sh7fffff, 24'sh800000, 24'shffffff,
			24'sh000001, 24'sh555555, 24'shaaaaaa, 24'sh400000,
			24'shc00000, 24'sh7fffff, 24'sh7fffff, 24'sh800000,
			24'sh800000, 24'sh0000ff, 24'shffff00, 24'sh123456};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph > 0) begin
				drain();
				case (ph)
					1: set_coefs(16'hffff, 16'h0000, 16'hffff);
					2: set_coefs(16'h0000, 16'hffff, 16'h0000);
					3: set_coefs(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
					4: set_coefs(16'h8000, 16'h8000, 16'h8000);
					default: set_coefs(COEF_W'($urandom_range(60000, 65535)),
						COEF_W'($urandom), 16'hffff);
				endcase
			end
			// sender idles lightly first, then heavily, then neither side idles
			if (ph < 2) begin
				tx_idle_pct = 9;
				rx_idle_pct = 51;
			end else if (ph < 4) begin
				tx_idle_pct = 51;
				rx_idle_pct = 9;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			// corner values, full-scale among them, with the period flag toggling
			if (ph == 0) begin
				for (int i = 0; i < 16; i++) begin
					send_beat(corner[i], i[0]);
				end
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick_sample(s, f);
				send_beat(s, f);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("comb_allpass_reverb verification clean");
		end else begin
			$display("comb_allpass_reverb verification failed");
		end
		$finish;
	end

endmodule
